// ----- hdl/adcwtq_pkg.sv -----
`default_nettype none

package adcwtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int NUM_CH  = 4;
    localparam int CH_W    = 2;
    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int IVL_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic [IVL_W-1:0] INTERVAL_RESET = 32'd20;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIN_CH0  = 3'd1;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

endpackage

`default_nettype wire

// ----- hdl/adc_window_trigger_event_queue.sv -----
// ADC window trigger event queue.
// Slave stream takes command words: tuser holds the command (tick, pop,
// stream start, stream stop), tdata the times, the four samples and the
// per-channel conversion-ok bits. Master stream returns one word per command:
// tuser flags whether a popped event is present and whether it is a trigger,
// tdata carries the event and the three wrapping counters.
// Window and interval registers are written through the plain config port;
// the user must write them only while the block is idle, which the block does
// not enforce. Invalid windows and a zero interval are ignored. Pop, start,
// stop and a tick that does no round go from idle to the done state, which
// loads the output register and raises tvalid once that register is free; a
// sampling round first passes the tick state, taking each possible event
// (4 channels x sample/trigger) in turn on the single write port of the event
// ring. One command is in work at a time; the next is accepted once the
// previous result is in the output register. A stalled master side holds the
// output word; one further command can be processed meanwhile and then waits
// for the output register. Reset (synchronous, active low) empties the ring,
// stops streaming and clears the counters; ring contents are not cleared.
`default_nettype none

module adc_window_trigger_event_queue #(
    parameter int QUEUE_DEPTH = adcwtq_pkg::QUEUE_DEPTH_DEF,
    parameter int SAMPLE_BITS = adcwtq_pkg::SAMPLE_BITS_DEF,
    parameter int WIN_W       = 2 * SAMPLE_BITS + 1,
    parameter int CFG_W       = (WIN_W > adcwtq_pkg::IVL_W) ? WIN_W : adcwtq_pkg::IVL_W,
    parameter int IN_DW       = 2 * adcwtq_pkg::TIME_W + adcwtq_pkg::NUM_CH * SAMPLE_BITS
                                + adcwtq_pkg::NUM_CH,
    parameter int IN_TW       = ((IN_DW + 7) / 8) * 8,
    parameter int OUT_DW      = 2 * adcwtq_pkg::TIME_W + adcwtq_pkg::CH_W + SAMPLE_BITS
                                + 3 * adcwtq_pkg::CNT_W,
    parameter int OUT_TW      = ((OUT_DW + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [adcwtq_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms, now_us, sample_ch0..sample_ch3, sample_ok
    input  wire logic [IN_TW-1:0]              s_axis_tdata,
    // command
    input  wire logic [adcwtq_pkg::CMD_W-1:0]  s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // event_ms, event_us, event_channel, event_value, samples_taken,
    // triggers_seen, events_dropped
    output logic      [OUT_TW-1:0]             m_axis_tdata,
    // pop_valid, event_is_trigger
    output logic      [1:0]                    m_axis_tuser
);

    localparam int TW     = adcwtq_pkg::TIME_W;
    localparam int NCH    = adcwtq_pkg::NUM_CH;
    localparam int WORD_W = 2 * TW + adcwtq_pkg::CH_W + SAMPLE_BITS + 1;

    logic [adcwtq_pkg::IVL_W-1:0]      interval;
    logic [NCH-1:0][WIN_W-1:0]         win;
    logic [NCH-1:0][SAMPLE_BITS-1:0]   smp;
    logic [NCH-1:0]                    ok;
    adcwtq_pkg::t_ring_ctl             ring_ctl;
    logic [WORD_W-1:0]                 push_word;
    logic [WORD_W-1:0]                 rd_word;
    logic                              empty;
    logic [adcwtq_pkg::CNT_W-1:0]      drops;

    logic                              pop_valid;
    logic [TW-1:0]                     event_ms;
    logic [TW-1:0]                     event_us;
    logic [adcwtq_pkg::CH_W-1:0]       event_channel;
    logic [SAMPLE_BITS-1:0]            event_value;
    logic                              event_is_trigger;
    logic [adcwtq_pkg::CNT_W-1:0]      samples_taken;
    logic [adcwtq_pkg::CNT_W-1:0]      triggers_seen;
    logic [adcwtq_pkg::CNT_W-1:0]      events_dropped;

    assign smp = s_axis_tdata[2*TW+NCH*SAMPLE_BITS-1:2*TW];
    assign ok  = s_axis_tdata[IN_DW-1:2*TW+NCH*SAMPLE_BITS];

    adcwtq_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN_W       (WIN_W),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_interval  (interval),
        .o_win       (win)
    );

    adcwtq_ring #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .i_wdata (push_word),
        .o_rdata (rd_word),
        .o_empty (empty),
        .o_drops (drops)
    );

    adcwtq_seq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN_W       (WIN_W),
        .WORD_W      (WORD_W)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (s_axis_tvalid),
        .o_in_ready         (s_axis_tready),
        .i_cmd              (s_axis_tuser),
        .i_now_ms           (s_axis_tdata[TW-1:0]),
        .i_now_us           (s_axis_tdata[2*TW-1:TW]),
        .i_smp              (smp),
        .i_ok               (ok),
        .i_interval         (interval),
        .i_win              (win),
        .o_ring             (ring_ctl),
        .o_push_word        (push_word),
        .i_empty            (empty),
        .i_rd_word          (rd_word),
        .i_drops            (drops),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_pop_valid        (pop_valid),
        .o_event_ms         (event_ms),
        .o_event_us         (event_us),
        .o_event_channel    (event_channel),
        .o_event_value      (event_value),
        .o_event_is_trigger (event_is_trigger),
        .o_samples_taken    (samples_taken),
        .o_triggers_seen    (triggers_seen),
        .o_events_dropped   (events_dropped)
    );

    assign m_axis_tdata = OUT_TW'({events_dropped, triggers_seen, samples_taken,
                                   event_value, event_channel, event_us, event_ms});
    assign m_axis_tuser = {event_is_trigger, pop_valid};

endmodule

`default_nettype wire

// ----- hdl/adcwtq_cfg.sv -----
`default_nettype none

module adcwtq_cfg #(
    parameter int SAMPLE_BITS = adcwtq_pkg::SAMPLE_BITS_DEF,
    parameter int WIN_W       = 2 * SAMPLE_BITS + 1,
    parameter int CFG_W       = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [adcwtq_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [CFG_W-1:0]                       i_cfg_data,
    output logic      [adcwtq_pkg::IVL_W-1:0]           o_interval,
    output logic      [adcwtq_pkg::NUM_CH-1:0][WIN_W-1:0] o_win
);

    localparam logic [WIN_W-1:0] WIN_RESET =
        {1'b0, {SAMPLE_BITS{1'b1}}, {SAMPLE_BITS{1'b0}}};

    logic [adcwtq_pkg::IVL_W-1:0] r_interval;
    logic [adcwtq_pkg::IVL_W-1:0] n_interval;
    logic [adcwtq_pkg::NUM_CH-1:0][WIN_W-1:0] r_win;
    logic [adcwtq_pkg::NUM_CH-1:0][WIN_W-1:0] n_win;
    logic [WIN_W-1:0]             wv;
    logic                         win_ok;

    assign wv     = i_cfg_data[WIN_W-1:0];
    assign win_ok = wv[SAMPLE_BITS-1:0] <= wv[2*SAMPLE_BITS-1:SAMPLE_BITS];

    always_comb begin
        n_interval = r_interval;
        n_win      = r_win;
        if (i_cfg_we && i_cfg_index == adcwtq_pkg::REG_INTERVAL
                && i_cfg_data[adcwtq_pkg::IVL_W-1:0] != '0) begin
            n_interval = i_cfg_data[adcwtq_pkg::IVL_W-1:0];
        end
        for (int c = 0; c < adcwtq_pkg::NUM_CH; c++) begin
            if (i_cfg_we && win_ok
                    && i_cfg_index == adcwtq_pkg::REG_WIN_CH0 + adcwtq_pkg::IDX_W'(c)) begin
                n_win[c] = wv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= adcwtq_pkg::INTERVAL_RESET;
            r_win      <= {adcwtq_pkg::NUM_CH{WIN_RESET}};
        end else begin
            r_interval <= n_interval;
            r_win      <= n_win;
        end
    end

    assign o_interval = r_interval;
    assign o_win      = r_win;

endmodule

`default_nettype wire

// ----- hdl/adcwtq_ring.sv -----
`default_nettype none

module adcwtq_ring #(
    parameter int DEPTH = adcwtq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 79
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire adcwtq_pkg::t_ring_ctl         i_ctl,
    input  wire logic [WIDTH-1:0]              i_wdata,
    output logic      [WIDTH-1:0]              o_rdata,
    output logic                               o_empty,
    output logic      [adcwtq_pkg::CNT_W-1:0]  o_drops
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW-1:0]    wp_nxt;
    logic [PW-1:0]    rp_nxt;
    logic [adcwtq_pkg::CNT_W-1:0] r_drops;

    assign wp_nxt = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign rp_nxt = (r_rp == LAST) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_wp] <= i_wdata;
        end
        if (i_ctl.pop) begin
            r_rdata <= mem[r_rp];
        end
    end

    // full ring: oldest word is dropped and counted in o_drops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_drops <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wp <= wp_nxt;
                if (wp_nxt == r_rp) begin
                    r_rp    <= rp_nxt;
                    r_drops <= r_drops + 1'b1;
                end
            end else if (i_ctl.pop) begin
                r_rp <= rp_nxt;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_empty = r_wp == r_rp;
    assign o_drops = r_drops;

endmodule

`default_nettype wire

// ----- hdl/adcwtq_seq.sv -----
`default_nettype none

module adcwtq_seq #(
    parameter int SAMPLE_BITS = adcwtq_pkg::SAMPLE_BITS_DEF,
    parameter int WIN_W       = 2 * SAMPLE_BITS + 1,
    parameter int WORD_W      = 2 * adcwtq_pkg::TIME_W + adcwtq_pkg::CH_W + SAMPLE_BITS + 1
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_ready,
    input  wire logic [adcwtq_pkg::CMD_W-1:0]                i_cmd,
    input  wire logic [adcwtq_pkg::TIME_W-1:0]               i_now_ms,
    input  wire logic [adcwtq_pkg::TIME_W-1:0]               i_now_us,
    input  wire logic [adcwtq_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] i_smp,
    input  wire logic [adcwtq_pkg::NUM_CH-1:0]               i_ok,
    input  wire logic [adcwtq_pkg::IVL_W-1:0]                i_interval,
    input  wire logic [adcwtq_pkg::NUM_CH-1:0][WIN_W-1:0]    i_win,
    output adcwtq_pkg::t_ring_ctl                            o_ring,
    output logic      [WORD_W-1:0]                           o_push_word,
    input  wire logic                                        i_empty,
    input  wire logic [WORD_W-1:0]                           i_rd_word,
    input  wire logic [adcwtq_pkg::CNT_W-1:0]                i_drops,
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_ready,
    output logic                                             o_pop_valid,
    output logic      [adcwtq_pkg::TIME_W-1:0]               o_event_ms,
    output logic      [adcwtq_pkg::TIME_W-1:0]               o_event_us,
    output logic      [adcwtq_pkg::CH_W-1:0]                 o_event_channel,
    output logic      [SAMPLE_BITS-1:0]                      o_event_value,
    output logic                                             o_event_is_trigger,
    output logic      [adcwtq_pkg::CNT_W-1:0]                o_samples_taken,
    output logic      [adcwtq_pkg::CNT_W-1:0]                o_triggers_seen,
    output logic      [adcwtq_pkg::CNT_W-1:0]                o_events_dropped
);

    localparam int TW = adcwtq_pkg::TIME_W;
    localparam int KW = adcwtq_pkg::CH_W + 1;
    localparam logic [KW-1:0] K_LAST = KW'(2 * adcwtq_pkg::NUM_CH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    r_state;
    logic          r_stream;
    logic [TW-1:0] r_last;
    logic [TW-1:0] r_ms;
    logic [TW-1:0] r_us;
    logic [adcwtq_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] r_smp;
    logic [adcwtq_pkg::NUM_CH-1:0] r_ok;
    logic [KW-1:0] r_k;
    logic          r_popv;
    logic [adcwtq_pkg::CNT_W-1:0] r_samples;
    logic [adcwtq_pkg::CNT_W-1:0] r_triggers;
    logic          r_out_valid;

    logic [TW-1:0]                r_o_ms;
    logic [TW-1:0]                r_o_us;
    logic [adcwtq_pkg::CH_W-1:0]  r_o_ch;
    logic [SAMPLE_BITS-1:0]       r_o_val;
    logic                         r_o_trig;
    logic                         r_o_popv;
    logic [adcwtq_pkg::CNT_W-1:0] r_o_samples;
    logic [adcwtq_pkg::CNT_W-1:0] r_o_triggers;
    logic [adcwtq_pkg::CNT_W-1:0] r_o_drops;

    logic                         acc;
    logic                         due;
    logic [adcwtq_pkg::CH_W-1:0]  ch;
    logic                         trig;
    logic [SAMPLE_BITS-1:0]       v;
    logic [WIN_W-1:0]             w;
    logic                         outside;
    logic                         push;
    logic                         load;
    logic [TW-1:0]                elapsed;

    assign o_in_ready = r_state == ST_IDLE;
    assign acc        = i_in_valid && o_in_ready;
    assign elapsed    = i_now_ms - r_last;
    assign due        = r_stream && elapsed >= i_interval;

    assign ch      = r_k[KW-1:1];
    assign trig    = r_k[0];
    assign v       = r_smp[ch];
    assign w       = i_win[ch];
    assign outside = w[2*SAMPLE_BITS] && (v < w[SAMPLE_BITS-1:0]
                     || v > w[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign push    = r_state == ST_TICK && r_ok[ch] && (!trig || outside);
    assign load    = r_state == ST_DONE && (!r_out_valid || i_out_ready);

    assign o_ring.push = push;
    assign o_ring.pop  = acc && i_cmd == adcwtq_pkg::CMD_POP && !i_empty;
    assign o_push_word = {trig, ch, v, r_us, r_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stream    <= 1'b0;
            r_last      <= '0;
            r_k         <= '0;
            r_popv      <= 1'b0;
            r_samples   <= '0;
            r_triggers  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_popv  <= o_ring.pop;
                        r_state <= (i_cmd == adcwtq_pkg::CMD_TICK && due) ? ST_TICK : ST_DONE;
                        unique case (i_cmd)
                            adcwtq_pkg::CMD_TICK: begin
                                if (due) begin
                                    r_last  <= i_now_ms;
                                    r_k     <= '0;
                                end
                            end
                            adcwtq_pkg::CMD_POP: begin
                            end
                            adcwtq_pkg::CMD_START: begin
                                r_stream <= 1'b1;
                                r_last   <= i_now_ms;
                            end
                            adcwtq_pkg::CMD_STOP: begin
                                r_stream <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (push && !trig) begin
                        r_samples <= r_samples + 1'b1;
                    end
                    if (push && trig) begin
                        r_triggers <= r_triggers + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ms  <= i_now_ms;
            r_us  <= i_now_us;
            r_smp <= i_smp;
            r_ok  <= i_ok;
        end
    end

    // read word layout: trig, channel, value, us, ms from the top
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_popv     <= r_popv;
            r_o_ms       <= r_popv ? i_rd_word[TW-1:0] : '0;
            r_o_us       <= r_popv ? i_rd_word[2*TW-1:TW] : '0;
            r_o_val      <= r_popv ? i_rd_word[2*TW+SAMPLE_BITS-1:2*TW] : '0;
            r_o_ch       <= r_popv ? i_rd_word[WORD_W-2:2*TW+SAMPLE_BITS] : '0;
            r_o_trig     <= r_popv && i_rd_word[WORD_W-1];
            r_o_samples  <= r_samples;
            r_o_triggers <= r_triggers;
            r_o_drops    <= i_drops;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_pop_valid        = r_o_popv;
    assign o_event_ms         = r_o_ms;
    assign o_event_us         = r_o_us;
    assign o_event_channel    = r_o_ch;
    assign o_event_value      = r_o_val;
    assign o_event_is_trigger = r_o_trig;
    assign o_samples_taken    = r_o_samples;
    assign o_triggers_seen    = r_o_triggers;
    assign o_events_dropped   = r_o_drops;

endmodule

`default_nettype wire

// ----- test/tb_adc_window_trigger_event_queue.sv -----
`timescale 1ns / 1ps

module tb_adc_window_trigger_event_queue;

    localparam int CYCLE_LIMIT = 500000;
    localparam int CALM_TAIL   = 200;
    localparam int SETTLE      = 24;

    typedef enum logic [1:0] {STEP_WORD, STEP_REG, STEP_PAUSE} t_step_kind;

    typedef struct packed {
        t_step_kind                   kind;
        logic [1:0]                   cmd;
        logic [31:0]                  ms;
        logic [31:0]                  us;
        logic [3:0][11:0]             smp;
        logic [3:0]                   ok;
        logic [adcwtq_pkg::IDX_W-1:0] reg_idx;
        logic [31:0]                  reg_val;
    } t_step;

    typedef struct packed {
        logic        found;
        logic        trig;
        logic [31:0] ms;
        logic [31:0] us;
        logic [1:0]  ch;
        logic [11:0] val;
        logic [31:0] samples;
        logic [31:0] triggers;
        logic [31:0] drops;
    } t_popped;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // now_ms, now_us, sample_ch0..sample_ch3, sample_ok
    logic [119:0] s_axis_tdata = '0;
    // command
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // event_ms, event_us, event_channel, event_value, samples_taken,
    // triggers_seen, events_dropped
    logic [175:0] m_axis_tdata;
    // pop_valid, event_is_trigger
    logic [1:0]   m_axis_tuser;

    adc_window_trigger_event_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_step   pending_words[$];
    t_popped awaited_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      gap = 0;
    int      stall = 0;
    int      settle = SETTLE;
    bit      calm = 1'b0;
    t_step   cur;

    // predicted block state
    logic [31:0] ring_ms [64];
    logic [31:0] ring_us [64];
    logic [1:0]  ring_ch [64];
    logic [11:0] ring_val [64];
    logic        ring_trig [64];
    logic [5:0]  q_wr = '0;
    logic [5:0]  q_rd = '0;
    logic        streaming_on = 1'b0;
    logic [31:0] round_ms = '0;
    logic [31:0] n_samples = '0;
    logic [31:0] n_triggers = '0;
    logic [31:0] n_drops = '0;
    logic [31:0] interval = adcwtq_pkg::INTERVAL_RESET;
    logic [24:0] window [4] = '{default: 25'h0FFF000};

    // stimulus-side view, used only to shape the words
    logic        gen_stream = 1'b0;
    logic [31:0] gen_last = '0;
    logic [31:0] gen_ivl = adcwtq_pkg::INTERVAL_RESET;
    logic [11:0] gen_lo [4] = '{default: 12'h000};
    logic [11:0] gen_hi [4] = '{default: 12'hFFF};

    task automatic ring_store(input logic [31:0] ms, input logic [31:0] us,
                              input logic [1:0] ch, input logic [11:0] val,
                              input logic trig);
        if (6'(q_wr + 6'd1) == q_rd) begin
            q_rd = 6'(q_rd + 6'd1);
            n_drops = n_drops + 32'd1;
        end
        ring_ms[q_wr]   = ms;
        ring_us[q_wr]   = us;
        ring_ch[q_wr]   = ch;
        ring_val[q_wr]  = val;
        ring_trig[q_wr] = trig;
        q_wr = 6'(q_wr + 6'd1);
    endtask

    task automatic apply_command(input t_step w);
        t_popped     r;
        logic [11:0] v;
        logic [1:0]  ch;
        r = '0;
        case (w.cmd)
            adcwtq_pkg::CMD_TICK: begin
                if (streaming_on && (w.ms - round_ms) >= interval) begin
                    round_ms = w.ms;
                    for (int c = 0; c < adcwtq_pkg::NUM_CH; c++) begin
                        if (w.ok[c]) begin
                            v  = w.smp[c];
                            ch = 2'(c);
                            n_samples = n_samples + 32'd1;
                            ring_store(w.ms, w.us, ch, v, 1'b0);
                            if (window[c][24] &&
                                (v < window[c][11:0] || v > window[c][23:12])) begin
                                n_triggers = n_triggers + 32'd1;
                                ring_store(w.ms, w.us, ch, v, 1'b1);
                            end
                        end
                    end
                end
            end
            adcwtq_pkg::CMD_POP: begin
                if (q_rd != q_wr) begin
                    r.found = 1'b1;
                    r.ms    = ring_ms[q_rd];
                    r.us    = ring_us[q_rd];
                    r.ch    = ring_ch[q_rd];
                    r.val   = ring_val[q_rd];
                    r.trig  = ring_trig[q_rd];
                    q_rd    = 6'(q_rd + 6'd1);
                end
            end
            adcwtq_pkg::CMD_START: begin
                streaming_on = 1'b1;
                round_ms     = w.ms;
            end
            default: streaming_on = 1'b0;
        endcase
        r.samples  = n_samples;
        r.triggers = n_triggers;
        r.drops    = n_drops;
        awaited_results.push_back(r);
    endtask

    task automatic apply_register(input logic [adcwtq_pkg::IDX_W-1:0] idx,
                                  input logic [31:0] d);
        int c;
        c = int'(idx) - int'(adcwtq_pkg::REG_WIN_CH0);
        if (idx == adcwtq_pkg::REG_INTERVAL) begin
            if (d != 32'd0) interval = d;
        end else if (c >= 0 && c < adcwtq_pkg::NUM_CH) begin
            if (d[11:0] <= d[23:12]) window[c] = d[24:0];
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            $display("mismatch at %0t: %s got %h want %h", $time, name, got, want);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] win_word(input logic [11:0] lo, input logic [11:0] hi,
                                             input logic en);
        return {7'd0, en, hi, lo};
    endfunction

    task automatic queue_command(input logic [1:0] cmd, input logic [31:0] ms,
                                 input logic [31:0] us, input logic [3:0][11:0] smp,
                                 input logic [3:0] ok);
        t_step s;
        s = '0;
        s.kind = STEP_WORD;
        s.cmd  = cmd;
        s.ms   = ms;
        s.us   = us;
        s.smp  = smp;
        s.ok   = ok;
        case (cmd)
            adcwtq_pkg::CMD_TICK:  if (gen_stream && (ms - gen_last) >= gen_ivl) gen_last = ms;
            adcwtq_pkg::CMD_START: begin
                gen_stream = 1'b1;
                gen_last   = ms;
            end
            adcwtq_pkg::CMD_STOP:  gen_stream = 1'b0;
            default: ;
        endcase
        pending_words.push_back(s);
    endtask

    task automatic queue_register(input logic [adcwtq_pkg::IDX_W-1:0] idx,
                                  input logic [31:0] d);
        t_step s;
        int    c;
        s = '0;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = d;
        c = int'(idx) - int'(adcwtq_pkg::REG_WIN_CH0);
        if (idx == adcwtq_pkg::REG_INTERVAL) begin
            if (d != 32'd0) gen_ivl = d;
        end else if (c >= 0 && c < adcwtq_pkg::NUM_CH && d[11:0] <= d[23:12]) begin
            gen_lo[c] = d[11:0];
            gen_hi[c] = d[23:12];
        end
        pending_words.push_back(s);
    endtask

    task automatic queue_pause();
        t_step s;
        s = '0;
        s.kind = STEP_PAUSE;
        pending_words.push_back(s);
    endtask

    function automatic logic [11:0] pick_sample(input int c);
        case ($urandom_range(0, 5))
            0: return 12'(gen_lo[c] - 12'd1);
            1: return gen_lo[c];
            2: return gen_hi[c];
            3: return 12'(gen_hi[c] + 12'd1);
            default: return 12'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        logic  nv;
        logic  we_n;
        t_step step;
        nv   = s_axis_tvalid && !s_axis_tready;
        we_n = 1'b0;
        if (s_axis_tvalid && s_axis_tready) apply_command(cur);
        calm = pending_words.size() < CALM_TAIL;
        if (i_rst_n && !nv) begin
            if (gap != 0) begin
                gap--;
            end else if (pending_words.size() != 0) begin
                case (pending_words[0].kind)
                    STEP_WORD: begin
                        cur = pending_words.pop_front();
                        nv  = 1'b1;
                        s_axis_tdata <= {4'd0, cur.ok, cur.smp, cur.us, cur.ms};
                        s_axis_tuser <= cur.cmd;
                        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
                    end
                    STEP_REG: begin
                        step = pending_words.pop_front();
                        we_n = 1'b1;
                        i_cfg_index <= step.reg_idx;
                        i_cfg_data  <= step.reg_val;
                        apply_register(step.reg_idx, step.reg_val);
                    end
                    default: begin
                        // hold off until the block has drained and settled
                        if (awaited_results.size() != 0) begin
                            settle = SETTLE;
                        end else if (settle != 0) begin
                            settle--;
                        end else begin
                            void'(pending_words.pop_front());
                            settle = SETTLE;
                        end
                    end
                endcase
            end
        end
        s_axis_tvalid <= nv;
        i_cfg_we      <= we_n;
    end

    // monitor
    always @(posedge i_clk) begin : watch
        logic    nr;
        t_popped want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                compare_field("unexpected word", 32'd1, 32'd0);
            end else begin
                want = awaited_results.pop_front();
                compare_field("pop_valid", 32'(m_axis_tuser[0]), 32'(want.found));
                compare_field("event_is_trigger", 32'(m_axis_tuser[1]), 32'(want.trig));
                compare_field("event_ms", m_axis_tdata[31:0], want.ms);
                compare_field("event_us", m_axis_tdata[63:32], want.us);
                compare_field("event_channel", 32'(m_axis_tdata[65:64]), 32'(want.ch));
                compare_field("event_value", 32'(m_axis_tdata[77:66]), 32'(want.val));
                compare_field("samples_taken", m_axis_tdata[109:78], want.samples);
                compare_field("triggers_seen", m_axis_tdata[141:110], want.triggers);
                compare_field("events_dropped", m_axis_tdata[173:142], want.drops);
            end
        end
        if (stall != 0) begin
            stall--;
            nr = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 11);
            nr    = 1'b0;
        end else begin
            nr = 1'b1;
        end
        m_axis_tready <= nr;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_adc_window_trigger_event_queue: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [3:0][11:0] smp;
        logic [31:0]      d;
        logic [31:0]      delta;
        logic [32:0]      wide;
        logic [11:0]      lo;
        logic [11:0]      hi;
        int               r;
        int               pop_pct;

        // directed: empty pop, idle tick, wrap of the round timer
        queue_command(adcwtq_pkg::CMD_POP, 32'd0, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd100, 32'h1234_5678, {4{12'hFFF}}, 4'hF);
        queue_command(adcwtq_pkg::CMD_STOP, 32'd0, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_START, 32'hFFFF_FFF0, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'd1, {4{12'h123}}, 4'hF);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd4, 32'hFFFF_FFFF,
                      {12'h555, 12'hAAA, 12'hFFF, 12'h000}, 4'hF);
        queue_command(adcwtq_pkg::CMD_POP, 32'd5, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_START, 32'd10, 32'd0, '0, 4'h0);  // restart while on
        queue_command(adcwtq_pkg::CMD_TICK, 32'd29, 32'd2, {4{12'h001}}, 4'hF);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd30, 32'd3, {4{12'h002}}, 4'h0);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd50, 32'd4,
                      {12'h800, 12'h7FF, 12'h400, 12'h3FF}, 4'hA);

        queue_pause();
        queue_register(adcwtq_pkg::REG_INTERVAL, 32'd0);                       // ignored
        queue_register(adcwtq_pkg::REG_WIN_CH0, win_word(12'd100, 12'd200, 1'b1));
        queue_register(adcwtq_pkg::IDX_W'(adcwtq_pkg::REG_WIN_CH0 + 1),
                       win_word(12'd500, 12'd400, 1'b1));                      // ignored
        queue_register(adcwtq_pkg::IDX_W'(adcwtq_pkg::REG_WIN_CH0 + 1),
                       win_word(12'd0, 12'd4095, 1'b1));
        queue_register(adcwtq_pkg::IDX_W'(adcwtq_pkg::REG_WIN_CH0 + 2),
                       win_word(12'd2048, 12'd2048, 1'b1));
        queue_register(adcwtq_pkg::IDX_W'(adcwtq_pkg::REG_WIN_CH0 + 3),
                       win_word(12'd1, 12'd4094, 1'b1));
        queue_register(adcwtq_pkg::REG_INTERVAL, 32'd1);

        // window edges, then enough trigger rounds to overflow the ring
        queue_command(adcwtq_pkg::CMD_TICK, 32'd51, 32'd51,
                      {12'd0, 12'd2048, 12'd4095, 12'd99}, 4'hF);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd52, 32'd52,
                      {12'd4095, 12'd2049, 12'd0, 12'd201}, 4'hF);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd53, 32'd53,
                      {12'd1, 12'd2047, 12'd2000, 12'd200}, 4'hF);
        for (int k = 0; k < 6; k++)
            queue_command(adcwtq_pkg::CMD_TICK, 32'(54 + k), 32'(k),
                          {12'd4095, 12'd0, 12'd7, 12'd0}, 4'hF);
        for (int k = 0; k < 3; k++)
            queue_command(adcwtq_pkg::CMD_POP, 32'd60, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_STOP, 32'd61, 32'd0, '0, 4'h0);
        queue_command(adcwtq_pkg::CMD_TICK, 32'd100, 32'd0, {4{12'hFFF}}, 4'hF);

        for (int p = 0; p < 6; p++) begin
            queue_pause();
            case (p)
                1: d = 32'hFFFF_FFFF;
                2: d = 32'd1;
                default: d = $urandom_range(1, 40);
            endcase
            if (p == 3) queue_register(adcwtq_pkg::REG_INTERVAL, 32'd0);
            queue_register(adcwtq_pkg::REG_INTERVAL, d);
            for (int c = 0; c < adcwtq_pkg::NUM_CH; c++) begin
                lo = 12'($urandom);
                hi = 12'($urandom_range(int'(lo), 4095));
                if (p == 4) begin
                    case (c)
                        0: begin lo = 12'd0;    hi = 12'd4095; end
                        1: begin lo = 12'd4095; hi = 12'd4095; end
                        2: begin lo = 12'd0;    hi = 12'd0;    end
                        default: ;
                    endcase
                end else if ($urandom_range(0, 5) == 0 && lo != 12'd0) begin
                    hi = 12'($urandom_range(0, int'(lo) - 1));  // low above high
                end
                d = $urandom;
                d[23:0] = {hi, lo};
                if (p == 4) d[24] = 1'b1;
                queue_register(adcwtq_pkg::IDX_W'(int'(adcwtq_pkg::REG_WIN_CH0) + c), d);
            end
            pop_pct = (p == 2 || p == 5) ? 55 : 28;
            queue_command(adcwtq_pkg::CMD_START, $urandom, $urandom, '0, 4'h0);
            for (int n = 0; n < 300; n++) begin
                r = $urandom_range(0, 99);
                for (int c = 0; c < adcwtq_pkg::NUM_CH; c++) smp[c] = pick_sample(c);
                if (r < 8) begin
                    queue_command(2'($urandom), $urandom, $urandom,
                                  {12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)},
                                  4'($urandom));
                end else if (r < 14) begin
                    queue_command(adcwtq_pkg::CMD_START, gen_last + $urandom_range(0, 50),
                                  $urandom, smp, 4'($urandom));
                end else if (r < 18) begin
                    queue_command(adcwtq_pkg::CMD_STOP, $urandom, $urandom, smp,
                                  4'($urandom));
                end else if (r < 18 + pop_pct) begin
                    queue_command(adcwtq_pkg::CMD_POP, $urandom, $urandom, smp,
                                  4'($urandom));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            wide  = {1'b0, gen_ivl} + 33'($urandom_range(0, 3));
                            delta = wide[32] ? gen_ivl : wide[31:0];
                        end
                        6, 7, 8: delta = $urandom_range(0, gen_ivl - 32'd1);
                        default: delta = $urandom;
                    endcase
                    queue_command(adcwtq_pkg::CMD_TICK, gen_last + delta, $urandom, smp,
                                  ($urandom_range(0, 4) < 3) ? 4'hF : 4'($urandom));
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || awaited_results.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb_adc_window_trigger_event_queue: PASS");
        end else begin
            $display("tb_adc_window_trigger_event_queue: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/adcwtq_pkg.sv
hdl/adcwtq_cfg.sv
hdl/adcwtq_ring.sv
hdl/adcwtq_seq.sv
hdl/adc_window_trigger_event_queue.sv
test/tb_adc_window_trigger_event_queue.sv
